// ===== hdl/ckh_pkg.sv =====
// shared types, constants and hash helper for the checksum keyed hash table
`default_nettype none

package ckh_pkg;

  localparam int KEY_W    = 64;
  localparam int OFFS_W   = 32;
  localparam int HASH_W   = 32;
  localparam int SIZE_W   = 11;
  localparam int IDX_W    = 10;
  localparam int OP_W     = 2;
  localparam int CNT_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int ENTRY_W  = 2 * KEY_W + OFFS_W;

  localparam int DEFAULT_DEPTH = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // register word index on the configuration port
  localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'h0000_0010;
  localparam int                HASH_ROT  = 9;
  localparam logic [HASH_W-1:0] HASH_ZERO_SUB = 32'hFFFF_FFFF;

  // four hash rounds per step, last step index
  localparam logic [CNT_W-1:0] HASH_LAST = 5'd3;
  localparam logic [CNT_W-1:0] MOD_LAST  = 5'd31;

  typedef struct packed {
    logic             load;
    logic             clear;
    logic             hash_step;
    logic             mod_step;
    logic             mem_rd;
    logic             update;
    logic [CNT_W-1:0] step;
  } ckh_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ckh_stat_t;

  // rotate left and add, one byte at a time, msb byte first
  function automatic logic [HASH_W-1:0] hash_word(input logic [HASH_W-1:0] h,
                                                  input logic [31:0] w);
    logic [HASH_W-1:0] acc;
    acc = h;
    for (int b = 3; b >= 0; b--) begin
      acc = ((acc << HASH_ROT) | (acc >> (HASH_W - HASH_ROT))) + {24'd0, w[8*b +: 8]};
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ckh_ctrl.sv =====
// controller state machine: sequences clear pass, hash, modulo, memory access
`default_nettype none

module ckh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ckh_pkg::ckh_stat_t stat_i,
  output ckh_pkg::ckh_cmd_t      cmd_o
);
  import ckh_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_UPDATE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.step  = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (cnt_q == HASH_LAST) begin
          cnt_d   = '0;
          state_d = ST_MOD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == MOD_LAST) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold here while the previous result is still waiting
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/ckh_datapath.sv =====
// datapath: input latch, hash rounds, restoring modulo, slot memory, result registers
`default_nettype none

module ckh_datapath #(
  parameter int TABLE_DEPTH = ckh_pkg::DEFAULT_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ckh_pkg::ckh_cmd_t           cmd_i,
  output ckh_pkg::ckh_stat_t               stat_o,
  input  wire logic [ckh_pkg::SIZE_W-1:0]  table_size_i,
  input  wire logic [ckh_pkg::OP_W-1:0]    op_i,
  input  wire logic [ckh_pkg::KEY_W-1:0]   sum_high_i,
  input  wire logic [ckh_pkg::KEY_W-1:0]   sum_low_i,
  input  wire logic [ckh_pkg::OFFS_W-1:0]  rec_offset_i,
  input  wire logic [ckh_pkg::IDX_W-1:0]   slot_index_i,
  output logic                             ok_o,
  output logic [ckh_pkg::SIZE_W-1:0]       slot_number_o,
  output logic [ckh_pkg::OFFS_W-1:0]       stored_offset_o,
  output logic [ckh_pkg::HASH_W-1:0]       hash_value_o
);
  import ckh_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [31:0]   DEPTH32   = 32'(TABLE_DEPTH);

  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   hi_q, lo_q;
  logic [OFFS_W-1:0]  offs_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [HASH_W-1:0]  hash_q, hash_fix;
  logic [SIZE_W-1:0]  rem_q;
  logic [SIZE_W:0]    rem_sh;
  logic [31:0]        round_word;
  logic [ENTRY_W-1:0] rd_q;
  logic [AW-1:0]      clr_addr_q;
  logic [AW-1:0]      acc_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;
  logic               idx_in_range;

  logic [KEY_W-1:0]   rd_hi, rd_lo;
  logic [OFFS_W-1:0]  rd_offs;

  logic               ok_d;
  logic [SIZE_W-1:0]  num_d;
  logic [OFFS_W-1:0]  prev_d;
  logic               upd_wr;
  logic [ENTRY_W-1:0] upd_data;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  // effective size: zero acts as one, clamp to the depth
  always_comb begin
    size_d = table_size_i;
    if (table_size_i == '0) begin
      size_d = SIZE_W'(1);
    end else if ({21'd0, table_size_i} > DEPTH32) begin
      size_d = SIZE_W'(TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      hi_q   <= sum_high_i;
      lo_q   <= sum_low_i;
      offs_q <= rec_offset_i;
      idx_q  <= slot_index_i;
      size_q <= size_d;
    end
  end

  // hash rounds, four key bytes per step
  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    round_word = hi_q[63:32];
      2'd1:    round_word = hi_q[31:0];
      2'd2:    round_word = lo_q[63:32];
      default: round_word = lo_q[31:0];
    endcase
  end

  assign hash_fix = (hash_q == '0) ? HASH_ZERO_SUB : hash_q;

  // restoring remainder, hash bits msb first
  assign rem_sh = {rem_q, hash_fix[~cmd_i.step]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hash_q <= HASH_SEED;
      rem_q  <= '0;
    end else begin
      if (cmd_i.hash_step) begin
        hash_q <= hash_word(hash_q, round_word);
      end
      if (cmd_i.mod_step) begin
        if (rem_sh >= {1'b0, size_q}) begin
          rem_q <= SIZE_W'(rem_sh - {1'b0, size_q});
        end else begin
          rem_q <= SIZE_W'(rem_sh);
        end
      end
    end
  end

  assign idx_in_range = ({1'b0, idx_q} < size_q);
  assign acc_addr     = (op_q == OP_REMOVE) ? AW'(idx_q) : AW'(rem_q);

  assign rd_hi   = rd_q[ENTRY_W-1 -: KEY_W];
  assign rd_lo   = rd_q[OFFS_W +: KEY_W];
  assign rd_offs = rd_q[OFFS_W-1:0];

  always_comb begin
    ok_d     = 1'b0;
    num_d    = '0;
    prev_d   = '0;
    upd_wr   = 1'b0;
    upd_data = '0;
    case (op_q)
      OP_FIND: begin
        prev_d = rd_offs;
        if (rd_hi == hi_q && rd_lo == lo_q) begin
          ok_d  = 1'b1;
          num_d = rem_q + 1'b1;
        end
      end
      OP_INSERT: begin
        prev_d = rd_offs;
        if (rd_offs == '0) begin
          ok_d     = 1'b1;
          upd_wr   = 1'b1;
          upd_data = {hi_q, lo_q, offs_q};
        end
      end
      OP_REMOVE: begin
        if (idx_in_range) begin
          prev_d = rd_offs;
          ok_d   = 1'b1;
          upd_wr = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  assign stat_o.clear_last = (clr_addr_q == ADDR_LAST);

  assign wr_en   = cmd_i.clear || (cmd_i.update && upd_wr);
  assign wr_addr = cmd_i.clear ? clr_addr_q : acc_addr;
  assign wr_data = cmd_i.clear ? '0 : upd_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[acc_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ok_o            <= ok_d;
      slot_number_o   <= num_d;
      stored_offset_o <= prev_d;
      hash_value_o    <= hash_fix;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/checksum_keyed_hash_table_core.sv =====
// Direct-mapped table of 16-byte checksum keys with 32-bit offsets.
// Input channel (in_valid_i/in_ready_o) carries op, key halves, offset and
// slot index; output channel (out_valid_o/out_ready_i) returns ok, slot
// number, stored offset and key hash, one result per input transfer.
// An item passes through 4 hash steps of four key bytes, 32 steps of the
// bit-serial remainder by the table size, a memory read and an update before
// the next one can be taken; the result is valid on the cycle after the update.
// After reset the slot memory is swept to zero, one entry a cycle, over all
// TABLE_DEPTH entries; no item is taken during the sweep, but the table_size
// register can be written over the APB port at any time.
// A result waits in the output register while the receiver stalls; the next
// item may be taken meanwhile and then holds in its update cycle until the
// output register is free.
// table_size (word 0) is reduced to 1..TABLE_DEPTH when used.
`default_nettype none

module checksum_keyed_hash_table_core #(
  parameter int TABLE_DEPTH = ckh_pkg::DEFAULT_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ckh_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ckh_pkg::APB_DW-1:0]  pwdata,
  output logic [ckh_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ckh_pkg::OP_W-1:0]    op_i,
  input  wire logic [ckh_pkg::KEY_W-1:0]   sum_high_i,
  input  wire logic [ckh_pkg::KEY_W-1:0]   sum_low_i,
  input  wire logic [ckh_pkg::OFFS_W-1:0]  rec_offset_i,
  input  wire logic [ckh_pkg::IDX_W-1:0]   slot_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             ok_o,
  output logic [ckh_pkg::SIZE_W-1:0]       slot_number_o,
  output logic [ckh_pkg::OFFS_W-1:0]       stored_offset_o,
  output logic [ckh_pkg::HASH_W-1:0]       hash_value_o
);
  import ckh_pkg::*;

  logic [SIZE_W-1:0] table_size_q;
  logic              reg_sel;
  ckh_cmd_t          cmd;
  ckh_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == REG_TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      table_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = reg_sel ? {21'd0, table_size_q} : '0;

  ckh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ckh_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .table_size_i    (table_size_q),
    .op_i            (op_i),
    .sum_high_i      (sum_high_i),
    .sum_low_i       (sum_low_i),
    .rec_offset_i    (rec_offset_i),
    .slot_index_i    (slot_index_i),
    .ok_o            (ok_o),
    .slot_number_o   (slot_number_o),
    .stored_offset_o (stored_offset_o),
    .hash_value_o    (hash_value_o)
  );

`ifndef SYNTHESIS
  // one item in flight: no second transfer right after a transfer
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // no item is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !in_ready_o)
    else $error("input ready during clearing sweep");

  // datapath commands are mutually exclusive
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clear, cmd.hash_step, cmd.mod_step, cmd.mem_rd, cmd.update}))
    else $error("overlapping datapath commands");

  // a result update always presents a result
  a_update_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> out_valid_o)
    else $error("result update without output valid");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the checksum keyed hash table core
`timescale 1ns / 100ps

module tb;
  import ckh_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int STALL_PCT    = 32;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1150;
  localparam int POOL_MAX     = 24;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  sum_high;
    logic [KEY_W-1:0]  sum_low;
    logic [OFFS_W-1:0] rec_offset;
    logic [IDX_W-1:0]  slot_index;
  } table_op_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] slot_number;
    logic [OFFS_W-1:0] stored_offset;
    logic [HASH_W-1:0] hash_value;
  } table_reply_t;

  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } checksum_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [APB_AW-1:0]  paddr         = '0;
  logic [APB_DW-1:0]  pwdata        = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    op_i          = '0;
  logic [KEY_W-1:0]   sum_high_i    = '0;
  logic [KEY_W-1:0]   sum_low_i     = '0;
  logic [OFFS_W-1:0]  rec_offset_i  = '0;
  logic [IDX_W-1:0]   slot_index_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               ok_o;
  logic [SIZE_W-1:0]  slot_number_o;
  logic [OFFS_W-1:0]  stored_offset_o;
  logic [HASH_W-1:0]  hash_value_o;

  checksum_keyed_hash_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .op_i, .sum_high_i, .sum_low_i, .rec_offset_i, .slot_index_i,
    .out_valid_o, .out_ready_i,
    .ok_o, .slot_number_o, .stored_offset_o, .hash_value_o
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the slot memory and the size register
  logic [KEY_W-1:0]  key_hi_mem [DEPTH];
  logic [KEY_W-1:0]  key_lo_mem [DEPTH];
  logic [OFFS_W-1:0] offset_mem [DEPTH];
  logic [SIZE_W-1:0] size_reg;

  table_reply_t table_replies[$];
  checksum_t    key_pool[$];
  int           mismatches = 0;
  int           quiet = 0;
  bit           steady = 1'b0;

  function automatic logic [HASH_W-1:0] checksum_hash(input logic [KEY_W-1:0] hi,
                                                      input logic [KEY_W-1:0] lo);
    logic [2*KEY_W-1:0] bytes;
    logic [HASH_W-1:0]  h;
    bytes = {hi, lo};
    h = HASH_SEED;
    for (int i = 2 * KEY_W / 8 - 1; i >= 0; i--) begin
      h = ((h << HASH_ROT) | (h >> (HASH_W - HASH_ROT))) + {24'd0, bytes[8*i +: 8]};
    end
    return (h == '0) ? HASH_ZERO_SUB : h;
  endfunction

  // register value folded into 1..DEPTH
  function automatic logic [HASH_W-1:0] slots_in_use();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return {{(HASH_W-SIZE_W){1'b0}}, size_reg};
  endfunction

  function automatic logic [HASH_W-1:0] key_slot(input checksum_t k);
    return checksum_hash(k.hi, k.lo) % slots_in_use();
  endfunction

  function automatic table_reply_t apply_table_op(input table_op_t t);
    table_reply_t      r;
    logic [HASH_W-1:0] n;
    logic [HASH_W-1:0] slot;
    r = '0;
    n = slots_in_use();
    r.hash_value = checksum_hash(t.sum_high, t.sum_low);
    slot = r.hash_value % n;
    case (t.op)
      OP_FIND: begin
        r.stored_offset = offset_mem[slot];
        if (key_hi_mem[slot] == t.sum_high && key_lo_mem[slot] == t.sum_low) begin
          r.ok = 1'b1;
          r.slot_number = slot[SIZE_W-1:0] + 1'b1;
        end
      end
      OP_INSERT: begin
        r.stored_offset = offset_mem[slot];
        if (offset_mem[slot] == '0) begin
          key_hi_mem[slot] = t.sum_high;
          key_lo_mem[slot] = t.sum_low;
          offset_mem[slot] = t.rec_offset;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (t.slot_index < n) begin
          r.stored_offset = offset_mem[t.slot_index];
          key_hi_mem[t.slot_index] = '0;
          key_lo_mem[t.slot_index] = '0;
          offset_mem[t.slot_index] = '0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic table_op_t make_op(input logic [OP_W-1:0] op, input checksum_t k,
                                        input logic [OFFS_W-1:0] offs,
                                        input logic [IDX_W-1:0] idx);
    table_op_t t;
    t.op = op;
    t.sum_high = k.hi;
    t.sum_low = k.lo;
    t.rec_offset = offs;
    t.slot_index = idx;
    return t;
  endfunction

  function automatic checksum_t random_checksum();
    checksum_t k;
    k.hi = {$urandom, $urandom};
    k.lo = {$urandom, $urandom};
    return k;
  endfunction

  // mostly keys already seen, so finds hit and inserts collide
  function automatic table_op_t random_item();
    checksum_t         k;
    int                pick;
    logic [OFFS_W-1:0] offs;
    logic [IDX_W-1:0]  idx;
    if (key_pool.size() != 0 && $urandom_range(99) < 70) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k = ($urandom_range(15) == 0) ? checksum_t'('0) : random_checksum();
      if (key_pool.size() < POOL_MAX) key_pool.push_back(k);
      else key_pool[$urandom_range(POOL_MAX - 1)] = k;
    end
    offs = ($urandom_range(19) == 0) ? '0 : $urandom;
    idx = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) return make_op(OP_INSERT, k, offs, idx);
    if (pick < 70) return make_op(OP_FIND, k, offs, idx);
    if (pick < 95) begin
      if ($urandom_range(99) < 60) idx = IDX_W'(key_slot(k));
      return make_op(OP_REMOVE, k, offs, idx);
    end
    return make_op(OP_UNUSED, k, offs, idx);
  endfunction

  task automatic transfer_item(input table_op_t t);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= t.op;
    sum_high_i    <= t.sum_high;
    sum_low_i     <= t.sum_low;
    rec_offset_i  <= t.rec_offset;
    slot_index_i  <= t.slot_index;
    do @(posedge clk_i); while (!in_ready_o);
    table_replies.push_back(apply_table_op(t));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk_i);
  endtask

  // write table_size, then read it back
  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TABLE_SIZE, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    size_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[SIZE_W-1:0] !== value) begin
      $display("%0t: table_size read back expected %h actual %h", $time, value,
               prdata[SIZE_W-1:0]);
      mismatches++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    table_reply_t want;
    if (out_valid_o && out_ready_i) begin
      if (table_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none actual hash %h", $time,
                 hash_value_o);
        mismatches++;
      end else begin
        want = table_replies.pop_front();
        check_field("ok", want.ok, ok_o);
        check_field("slot_number", want.slot_number, slot_number_o);
        check_field("stored_offset", want.stored_offset, stored_offset_o);
        check_field("hash_value", want.hash_value, hash_value_o);
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  // counts cycles with no transfer on either channel, ends the test as failed at QUIET_LIMIT
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("checksum_keyed_hash_table_core test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic test_empty_table();
    transfer_item(make_op(OP_FIND, '0, $urandom, IDX_W'($urandom)));
    transfer_item(make_op(OP_FIND, random_checksum(), $urandom, IDX_W'($urandom)));
    transfer_item(make_op(OP_UNUSED, '1, '1, '1));
    transfer_item(make_op(OP_REMOVE, random_checksum(), '0, '1));
    drain();
  endtask

  task automatic test_single_ops();
    checksum_t ones;
    checksum_t other;
    ones = '1;
    other = random_checksum();
    transfer_item(make_op(OP_INSERT, ones, '1, '0));
    transfer_item(make_op(OP_FIND, ones, '0, '0));
    // occupied slot refuses a second insert
    transfer_item(make_op(OP_INSERT, ones, 32'd5, '0));
    // offset zero leaves the slot empty but keeps the key
    transfer_item(make_op(OP_INSERT, other, '0, '0));
    transfer_item(make_op(OP_FIND, other, '0, '0));
    transfer_item(make_op(OP_INSERT, other, $urandom | 32'd1, '0));
    transfer_item(make_op(OP_REMOVE, ones, '0, IDX_W'(key_slot(ones))));
    transfer_item(make_op(OP_FIND, ones, '0, '0));
    transfer_item(make_op(OP_REMOVE, ones, '0, '0));
    drain();
  endtask

  task automatic test_size_limits();
    checksum_t k;
    checksum_t other;
    k = random_checksum();
    other = random_checksum();
    write_table_size(11'd5);
    transfer_item(make_op(OP_REMOVE, k, '0, 10'd5));
    transfer_item(make_op(OP_REMOVE, k, '0, 10'd4));
    transfer_item(make_op(OP_REMOVE, k, '0, '1));
    drain();
    // zero acts as a single slot, so every key collides
    write_table_size(11'd0);
    transfer_item(make_op(OP_INSERT, k, $urandom | 32'd1, '0));
    transfer_item(make_op(OP_INSERT, other, $urandom, '0));
    transfer_item(make_op(OP_FIND, other, '0, '0));
    transfer_item(make_op(OP_FIND, k, '0, '0));
    transfer_item(make_op(OP_REMOVE, k, '0, 10'd1));
    transfer_item(make_op(OP_REMOVE, k, '0, 10'd0));
    drain();
    write_table_size('1);
    transfer_item(make_op(OP_REMOVE, k, '0, '1));
    transfer_item(make_op(OP_INSERT, '1, 32'd1, '0));
    transfer_item(make_op(OP_FIND, '1, '0, '0));
    drain();
  endtask

  task automatic test_random_traffic();
    logic [SIZE_W-1:0] sizes[10];
    sizes = '{11'd1024, 11'd7, 11'd1, 11'd0, 11'd2047, 11'd100, 11'd1023, 11'd1025,
              11'd3, 11'd1024};
    foreach (sizes[p]) begin
      write_table_size(sizes[p]);
      steady = (p == 0);
      repeat (RANDOM_ITEMS / 10) transfer_item(random_item());
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      key_hi_mem[i] = '0;
      key_lo_mem[i] = '0;
      offset_mem[i] = '0;
    end
    size_reg = TABLE_SIZE_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_single_ops();
    test_size_limits();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("checksum_keyed_hash_table_core test passed");
    end else begin
      $display("checksum_keyed_hash_table_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ckh_pkg.sv
hdl/ckh_ctrl.sv
hdl/ckh_datapath.sv
hdl/checksum_keyed_hash_table_core.sv
dv/tb.sv
